// ===== hdl/i2cram_pkg.sv =====
// Package: shared types and constants for the I2C register access master.
package i2cram_pkg;

	// Bus phase of the transaction sequencer
	typedef enum logic [3:0] {
		K_IDLE    = 4'd0,
		K_START_A = 4'd1,
		K_START_B = 4'd2,
		K_BIT_LO  = 4'd3,
		K_BIT_HI  = 4'd4,
		K_RS_A    = 4'd5,
		K_RS_B    = 4'd6,
		K_STOP_A  = 4'd7,
		K_STOP_B  = 4'd8,
		K_STOP_C  = 4'd9
	} step_kind_t;

	// Command codes
	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_DEVICE_ADDRESS = 1'b0;
	localparam logic CFG_PHASE_TICKS    = 1'b1;

	localparam logic [6:0]  DEVICE_ADDRESS_RESET = 7'd104;
	localparam logic [15:0] PHASE_TICKS_RESET    = 16'd1;

	// Line levels: bit 1 SCL, bit 0 SDA released
	localparam logic [1:0] LINES_HIGH = 2'b11;

	// Byte count at which a read clocks in its data byte
	localparam logic [2:0] RX_BYTE     = 3'd3;
	// Byte count after which a write sends STOP
	localparam logic [2:0] WR_BYTE_END = 3'd5;
	// Bit count of the acknowledge slot
	localparam logic [3:0] ACK_BIT     = 4'd8;
	localparam logic [3:0] BIT_END     = 4'd9;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] reg_address;
		logic [7:0] data_first;
		logic [7:0] data_second;
		logic [7:0] data_third;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic       ack_missing;
	} result_t;

endpackage

// ===== hdl/i2cram_in_reg.sv =====
// Input register: holds one accepted tick until the sequencer consumes it.
module i2cram_in_reg
	import i2cram_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  logic  consume,
	input  item_t item_in,
	output logic  valid_s1,
	output item_t item_s1
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

// ===== hdl/i2cram_seq.sv =====
// Transaction sequencer: bus state, counters, shift register and per-tick step logic.
module i2cram_seq
	import i2cram_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step_en,
	input  item_t       item_s1,
	input  logic [6:0]  device_address_q,
	input  logic [15:0] phase_ticks_q,
	output result_t     result
);

	step_kind_t  kind_q, nx_kind;
	logic        read_q, nx_read;
	logic [15:0] phase_q, nx_phase;
	logic [3:0]  bit_q, nx_bit;
	logic [2:0]  byte_q, nx_byte;
	logic [7:0]  shift_q, nx_shift;
	logic [7:0]  latched_q [4];
	logic [7:0]  nx_latched [4];
	logic [7:0]  recv_q, nx_recv;
	logic        ack_q, nx_ack;
	logic [1:0]  levels_q, nx_levels;

	// SDA release for a data bit low phase: released while receiving or in the ack slot
	function automatic logic sda_rel(logic rd, logic [2:0] byc, logic [3:0] bic,
		logic [7:0] sh);
		logic rel;
		if ((rd && byc == RX_BYTE) || bic >= ACK_BIT) begin
			rel = 1'b1;
		end else begin
			rel = sh[7];
		end
		return rel;
	endfunction

	always_comb begin
		logic [16:0] pc_inc;
		logic [15:0] len;
		logic        done;
		logic        rx;
		logic [3:0]  bc;
		logic [2:0]  byc;
		logic [2:0]  byc_m1;
		logic [7:0]  sh;

		nx_kind    = kind_q;
		nx_read    = read_q;
		nx_phase   = phase_q;
		nx_bit     = bit_q;
		nx_byte    = byte_q;
		nx_shift   = shift_q;
		nx_latched = latched_q;
		nx_recv    = recv_q;
		nx_ack     = ack_q;
		nx_levels  = levels_q;
		done       = 1'b0;
		pc_inc     = {1'b0, phase_q} + 17'd1;
		len        = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
		rx         = read_q && (byte_q == RX_BYTE);
		bc         = bit_q + 4'd1;
		byc        = byte_q + 3'd1;
		byc_m1     = byc - 3'd1;
		sh         = shift_q;

		if (kind_q == K_IDLE) begin
			if (item_s1.command == CMD_READ || item_s1.command == CMD_WRITE) begin
				nx_latched[0] = item_s1.reg_address;
				nx_latched[1] = item_s1.data_first;
				nx_latched[2] = item_s1.data_second;
				nx_latched[3] = item_s1.data_third;
				nx_ack        = 1'b0;
				nx_byte       = 3'd0;
				nx_bit        = 4'd0;
				nx_phase      = 16'd0;
				nx_shift      = {device_address_q, 1'b0};
				nx_read       = (item_s1.command == CMD_READ);
				nx_kind       = K_START_A;
				nx_levels     = LINES_HIGH;
			end
		end else if (pc_inc >= {1'b0, len}) begin
			nx_phase = 16'd0;
			unique case (kind_q)
				K_START_A: begin
					nx_kind   = K_START_B;
					nx_levels = 2'b10;
				end
				K_START_B: begin
					nx_kind   = K_BIT_LO;
					nx_levels = {1'b0, sda_rel(read_q, byte_q, bit_q, shift_q)};
				end
				K_BIT_LO: begin
					nx_kind   = K_BIT_HI;
					nx_levels = levels_q | 2'b10;
				end
				K_BIT_HI: begin
					// end of an SCL high phase: sample SDA
					if (bit_q < ACK_BIT) begin
						sh = {shift_q[6:0], rx & item_s1.sda_in};
					end else if (!rx) begin
						nx_ack = ack_q | item_s1.sda_in;
					end
					if (bc < BIT_END) begin
						nx_bit    = bc;
						nx_shift  = sh;
						nx_kind   = K_BIT_LO;
						nx_levels = {1'b0, sda_rel(read_q, byte_q, bc, sh)};
					end else begin
						nx_bit = 4'd0;
						if (rx) begin
							nx_recv   = sh;
							nx_shift  = sh;
							nx_kind   = K_STOP_A;
							nx_levels = 2'b00;
						end else begin
							nx_byte = byc;
							if (read_q) begin
								if (byc == 3'd1) begin
									sh        = latched_q[0];
									nx_kind   = K_BIT_LO;
									nx_levels = {1'b0, sda_rel(read_q, byc, 4'd0, sh)};
								end else if (byc == 3'd2) begin
									// read address byte, sent after the repeated start
									sh        = {device_address_q, 1'b1};
									nx_kind   = K_RS_A;
									nx_levels = 2'b01;
								end else begin
									sh        = 8'd0;
									nx_kind   = K_BIT_LO;
									nx_levels = {1'b0, sda_rel(read_q, byc, 4'd0, sh)};
								end
							end else if (byc >= WR_BYTE_END) begin
								nx_kind   = K_STOP_A;
								nx_levels = 2'b00;
							end else begin
								sh        = latched_q[byc_m1[1:0]];
								nx_kind   = K_BIT_LO;
								nx_levels = {1'b0, sda_rel(read_q, byc, 4'd0, sh)};
							end
							nx_shift = sh;
						end
					end
				end
				K_RS_A: begin
					nx_kind   = K_RS_B;
					nx_levels = LINES_HIGH;
				end
				K_RS_B: begin
					nx_kind   = K_START_B;
					nx_levels = 2'b10;
				end
				K_STOP_A: begin
					nx_kind   = K_STOP_B;
					nx_levels = 2'b10;
				end
				K_STOP_B: begin
					nx_kind   = K_STOP_C;
					nx_levels = LINES_HIGH;
				end
				K_STOP_C: begin
					nx_kind   = K_IDLE;
					nx_read   = 1'b0;
					nx_levels = LINES_HIGH;
					done      = 1'b1;
				end
				default: begin
					nx_kind   = K_IDLE;
					nx_read   = 1'b0;
					nx_levels = LINES_HIGH;
				end
			endcase
		end else begin
			nx_phase = pc_inc[15:0];
		end

		result.scl_level     = nx_levels[1];
		result.sda_drive_low = ~nx_levels[0];
		result.busy_res      = (nx_kind != K_IDLE);
		result.done_res      = done;
		result.read_data     = nx_recv;
		result.ack_missing   = nx_ack;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q    <= K_IDLE;
			read_q    <= 1'b0;
			phase_q   <= 16'd0;
			bit_q     <= 4'd0;
			byte_q    <= 3'd0;
			shift_q   <= 8'd0;
			latched_q <= '{default: 8'd0};
			recv_q    <= 8'd0;
			ack_q     <= 1'b0;
			levels_q  <= LINES_HIGH;
		end else if (step_en) begin
			kind_q    <= nx_kind;
			read_q    <= nx_read;
			phase_q   <= nx_phase;
			bit_q     <= nx_bit;
			byte_q    <= nx_byte;
			shift_q   <= nx_shift;
			latched_q <= nx_latched;
			recv_q    <= nx_recv;
			ack_q     <= nx_ack;
			levels_q  <= nx_levels;
		end
	end

endmodule

// ===== hdl/i2cram_out_reg.sv =====
// Result register: holds one tick's result until the receiver takes it.
module i2cram_out_reg
	import i2cram_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  logic    out_stall,
	input  result_t result_in,
	output logic    valid_q,
	output result_t result_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= load | (valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

// ===== hdl/i2c_register_access_master.sv =====
// Top level: I2C register access master, one bus tick per input transfer.
//
// Usage
//   Input channel (in_valid / in_stall): each transfer is one bus tick carrying
//   a command (read one register, write three bytes), its operands and the
//   sampled SDA level. Commands are only taken while the block is idle.
//   Output channel (out_valid / out_stall): one result transfer per tick with
//   the SCL level, SDA pull-down, busy, done pulse, last read byte and the
//   missing-acknowledge flag, all reflecting state after that tick.
//   Config port (cfg_write / cfg_index / cfg_data): index 0 device address,
//   index 1 ticks per SCL phase (0 acts as 1). Write while idle.
// Timing
//   An input transfer reaches the result through the input register, then
//   the sequencer step into the result register. Throughput is one tick per
//   cycle while out_stall does not hold a full result register.
// Reset
//   arst_n clears the sequencer to idle with both lines released high and
//   empties both registers; config returns to address 104, phase length 1.
// Stall
//   While out_stall holds a full result register, the sequencer freezes and
//   in_stall rises once the input register is also occupied.
module i2c_register_access_master
	import i2cram_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_write,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  reg_address,
	input  logic [7:0]  data_first,
	input  logic [7:0]  data_second,
	input  logic [7:0]  data_third,
	input  logic        sda_in,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_level,
	output logic        sda_drive_low,
	output logic        busy_res,
	output logic        done_res,
	output logic [7:0]  read_data,
	output logic        ack_missing
);

	logic [6:0]  device_address_q;
	logic [15:0] phase_ticks_q;
	item_t       item_in;
	item_t       item_s1;
	logic        valid_s1;
	logic        step_en;
	logic        in_load;
	result_t     result;
	result_t     result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEVICE_ADDRESS_RESET;
			phase_ticks_q    <= PHASE_TICKS_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_DEVICE_ADDRESS: device_address_q <= cfg_data[6:0];
				CFG_PHASE_TICKS:    phase_ticks_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	// the sequencer steps whenever a tick is held and the result register has room
	assign step_en  = valid_s1 & (~out_valid | ~out_stall);
	assign in_stall = valid_s1 & ~step_en;
	assign in_load  = in_valid & ~in_stall;

	assign item_in.command     = command;
	assign item_in.reg_address = reg_address;
	assign item_in.data_first  = data_first;
	assign item_in.data_second = data_second;
	assign item_in.data_third  = data_third;
	assign item_in.sda_in      = sda_in;

	i2cram_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_load),
		.consume  (step_en),
		.item_in  (item_in),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	i2cram_seq u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (step_en),
		.item_s1          (item_s1),
		.device_address_q (device_address_q),
		.phase_ticks_q    (phase_ticks_q),
		.result           (result)
	);

	i2cram_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step_en),
		.out_stall (out_stall),
		.result_in (result),
		.valid_q   (out_valid),
		.result_q  (result_q)
	);

	assign scl_level     = result_q.scl_level;
	assign sda_drive_low = result_q.sda_drive_low;
	assign busy_res      = result_q.busy_res;
	assign done_res      = result_q.done_res;
	assign read_data     = result_q.read_data;
	assign ack_missing   = result_q.ack_missing;

endmodule

// ===== hdl/i2cram_checker.sv =====
// Checker: port-level assertions for the I2C register access master, with bind.
module i2cram_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       sda_drive_low,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] read_data
);

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data))
		else $error("result changed while stalled");

	// input only backs up when the result side is blocked
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free result register");

	// the stop completion leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done while still busy");

	// an idle bus has both lines released
	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !busy_res |-> scl_level && !sda_drive_low)
		else $error("lines not released while idle");

endmodule

bind i2c_register_access_master i2cram_checker u_checker (.*);
